### rtl/scfla_pkg.sv
// ----------------------------------------------------------------------------
// scfla_pkg - size-class free-list allocator package
// Default sizing, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package scfla_pkg;

  localparam int unsigned DEF_ALIGN_BYTES     = 8;
  localparam int unsigned DEF_MAX_CLASS_BYTES = 128;
  localparam int unsigned DEF_CLASS_COUNT     = 16;
  localparam int unsigned DEF_REFILL_OBJECTS  = 20;
  localparam int unsigned DEF_ARENA_BYTES     = 65536;

  localparam int unsigned ACTION_W = 1;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned BADDR_W  = 16;
  localparam int unsigned ADDR_W   = 16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_OVER,
    DP_FREE,
    DP_POP_RD,
    DP_POP_WB,
    DP_CHK,
    DP_PUSH_LEFT,
    DP_TAKE,
    DP_SCAN_INIT,
    DP_SCAN_NEXT,
    DP_FB_WB,
    DP_FAIL,
    DP_CARVE_FIRST,
    DP_CARVE_STEP,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_scan;   // pop from scan class rather than request class
  } dp_cmd_t;

  typedef struct packed {
    logic oversize;
    logic act_free;
    logic head_nil;
    logic left_lt;
    logic left_nz;
    logic region_fits;
    logic scan_nil;
    logic scan_last;
    logic carve_more;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/scfla_if.sv
// ----------------------------------------------------------------------------
// scfla_in_if / scfla_out_if - request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface scfla_in_if;
  logic                           valid;
  logic                           ready;
  logic [scfla_pkg::ACTION_W-1:0] action;
  logic [scfla_pkg::SIZE_W-1:0]   size_bytes;
  logic [scfla_pkg::BADDR_W-1:0]  block_address;

  modport source (output valid, action, size_bytes, block_address, input ready);
  modport sink   (input valid, action, size_bytes, block_address, output ready);
endinterface

interface scfla_out_if;
  logic                         valid;
  logic                         ready;
  logic [scfla_pkg::ADDR_W-1:0] address;
  logic                         granted;
  logic                         oversize;

  modport source (output valid, address, granted, oversize, input ready);
  modport sink   (input valid, address, granted, oversize, output ready);
endinterface

### rtl/scfla_dpath.sv
// ----------------------------------------------------------------------------
// scfla_dpath - allocator datapath
// Class heads, link memory, pool/arena registers and the result register.
// ----------------------------------------------------------------------------
module scfla_dpath #(
  parameter int unsigned ALIGN_BYTES     = scfla_pkg::DEF_ALIGN_BYTES,
  parameter int unsigned MAX_CLASS_BYTES = scfla_pkg::DEF_MAX_CLASS_BYTES,
  parameter int unsigned CLASS_COUNT     = scfla_pkg::DEF_CLASS_COUNT,
  parameter int unsigned REFILL_OBJECTS  = scfla_pkg::DEF_REFILL_OBJECTS,
  parameter int unsigned ARENA_BYTES     = scfla_pkg::DEF_ARENA_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scfla_pkg::dp_cmd_t             cmd,
  output scfla_pkg::dp_sts_t             sts,
  input  logic [scfla_pkg::ACTION_W-1:0] req_action,
  input  logic [scfla_pkg::SIZE_W-1:0]   req_size,
  input  logic [scfla_pkg::BADDR_W-1:0]  req_baddr,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [scfla_pkg::ADDR_W-1:0]   out_address,
  output logic                           out_granted,
  output logic                           out_oversize
);

  localparam int unsigned S   = $clog2(ALIGN_BYTES);
  localparam int unsigned AW  = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned LINK_DEPTH = ARENA_BYTES / ALIGN_BYTES;
  localparam int unsigned LW  = $clog2(LINK_DEPTH);
  localparam int unsigned CW  = $clog2(CLASS_COUNT);
  localparam int unsigned NW  = $clog2(REFILL_OBJECTS + 1);
  localparam int unsigned RW  =
    $clog2(2 * CLASS_COUNT * ALIGN_BYTES * REFILL_OBJECTS + 2 * ARENA_BYTES) + 1;
  localparam int unsigned SW  = scfla_pkg::SIZE_W + 1;
  localparam logic [AW-1:0] NIL = '1;

  // stores
  logic [AW-1:0] link_mem [LINK_DEPTH];
  logic [AW-1:0] heads_r   [CLASS_COUNT];
  logic [AW-1:0] heads_nxt [CLASS_COUNT];

  logic [AW-1:0] pool_s_r, pool_s_nxt, pool_e_r, pool_e_nxt;
  logic [AW-1:0] top_r, top_nxt, heap_r, heap_nxt;
  logic [RW-1:0] region_r, region_nxt;
  logic          act_r, act_nxt, over_r, over_nxt, bad_r, bad_nxt;
  logic [CW-1:0] cls_r, cls_nxt, k_r, k_nxt;
  logic [AW-1:0] baddr_r, baddr_nxt, blk_r, blk_nxt, rdata_r;
  logic [AW-1:0] ret_r, ret_nxt, prev_r, prev_nxt, rem_r, rem_nxt;
  logic          prev_v_r, prev_v_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic          res_grant_r, res_grant_nxt, res_over_r, res_over_nxt;
  logic          ov_r, ov_nxt;
  logic [scfla_pkg::ADDR_W-1:0] oa_r, oa_nxt;
  logic          og_r, og_nxt, oo_r, oo_nxt;

  logic          mem_we;
  logic [LW-1:0] mem_wa, mem_ra;
  logic [AW-1:0] mem_wd;

  // request decode
  logic [SW-1:0] gran;
  logic [CW-1:0] cls_in;
  logic [AW-1:0] bsz, bsz_k, left;
  logic [CW-1:0] left_cls;
  logic [AW-1:0] left_gran;
  logic [RW-1:0] heap_part, room;
  logic [AW-1:0] pop_head;

  always_comb begin
    gran = (SW'(req_size) + SW'(ALIGN_BYTES - 1)) >> S;
    if (gran == '0) cls_in = '0;
    else if (gran > SW'(CLASS_COUNT)) cls_in = CW'(CLASS_COUNT - 1);
    else cls_in = CW'(gran - SW'(1));
  end

  assign bsz   = AW'({1'b0, cls_r} + 1'b1) << S;
  assign bsz_k = AW'({1'b0, k_r} + 1'b1) << S;
  assign left  = pool_e_r - pool_s_r;

  always_comb begin
    left_gran = (left + AW'(ALIGN_BYTES - 1)) >> S;
    if (left_gran == '0) left_cls = '0;
    else if (left_gran > AW'(CLASS_COUNT)) left_cls = CW'(CLASS_COUNT - 1);
    else left_cls = CW'(left_gran - AW'(1));
  end

  assign heap_part = ((RW'(heap_r >> 4) + RW'(ALIGN_BYTES - 1)) >> S) << S;
  assign room      = RW'(ARENA_BYTES) - RW'(top_r);
  assign pop_head  = cmd.sel_scan ? heads_r[k_r] : heads_r[cls_r];

  always_comb begin
    sts.oversize    = over_r;
    sts.act_free    = act_r;
    sts.head_nil    = (heads_r[cls_r] == NIL);
    sts.left_lt     = (left < bsz);
    sts.left_nz     = (left != '0);
    sts.region_fits = (region_r <= room);
    sts.scan_nil    = (heads_r[k_r] == NIL);
    sts.scan_last   = (k_r == CW'(CLASS_COUNT - 1));
    sts.carve_more  = (cnt_r < NW'(REFILL_OBJECTS)) && (rem_r >= bsz);
    sts.out_free    = !ov_r || out_ready;
  end

  always_comb begin
    heads_nxt = heads_r;
    pool_s_nxt = pool_s_r;  pool_e_nxt = pool_e_r;
    top_nxt = top_r;        heap_nxt = heap_r;
    region_nxt = region_r;
    act_nxt = act_r;  over_nxt = over_r;  bad_nxt = bad_r;
    cls_nxt = cls_r;  k_nxt = k_r;
    baddr_nxt = baddr_r;  blk_nxt = blk_r;
    ret_nxt = ret_r;  prev_nxt = prev_r;  prev_v_nxt = prev_v_r;
    rem_nxt = rem_r;  cnt_nxt = cnt_r;
    res_addr_nxt = res_addr_r;  res_grant_nxt = res_grant_r;  res_over_nxt = res_over_r;
    ov_nxt = ov_r && !out_ready;
    oa_nxt = oa_r;  og_nxt = og_r;  oo_nxt = oo_r;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;
    mem_ra = pop_head[S +: LW];

    case (cmd.op)
      scfla_pkg::DP_LOAD: begin
        act_nxt   = (req_action == scfla_pkg::ACT_FREE);
        over_nxt  = (req_size > scfla_pkg::SIZE_W'(MAX_CLASS_BYTES));
        cls_nxt   = cls_in;
        baddr_nxt = AW'(req_baddr);
        bad_nxt   = (AW'(req_baddr) >= AW'(ARENA_BYTES)) ||
                    (req_baddr[S-1:0] != '0);
        res_addr_nxt = '0;  res_grant_nxt = 1'b0;  res_over_nxt = 1'b0;
      end
      scfla_pkg::DP_SET_OVER: res_over_nxt = 1'b1;
      scfla_pkg::DP_FREE: begin
        if (!bad_r) begin
          mem_we = 1'b1;
          mem_wa = baddr_r[S +: LW];
          mem_wd = heads_r[cls_r];
          heads_nxt[cls_r] = baddr_r;
          res_grant_nxt = 1'b1;
        end
      end
      scfla_pkg::DP_POP_RD: blk_nxt = pop_head;
      scfla_pkg::DP_POP_WB: begin
        heads_nxt[cls_r] = rdata_r;
        res_addr_nxt  = blk_r;
        res_grant_nxt = 1'b1;
      end
      scfla_pkg::DP_CHK:
        region_nxt = RW'(bsz) * RW'(2 * REFILL_OBJECTS) + heap_part;
      scfla_pkg::DP_PUSH_LEFT: begin
        mem_we = 1'b1;
        mem_wa = pool_s_r[S +: LW];
        mem_wd = heads_r[left_cls];
        heads_nxt[left_cls] = pool_s_r;
      end
      scfla_pkg::DP_TAKE: begin
        pool_s_nxt = top_r;
        pool_e_nxt = top_r + AW'(region_r);
        top_nxt    = top_r + AW'(region_r);
        heap_nxt   = heap_r + AW'(region_r);
      end
      scfla_pkg::DP_SCAN_INIT: k_nxt = cls_r;
      scfla_pkg::DP_SCAN_NEXT: k_nxt = k_r + 1'b1;
      scfla_pkg::DP_FB_WB: begin
        heads_nxt[k_r] = rdata_r;
        pool_s_nxt = blk_r;
        pool_e_nxt = blk_r + bsz_k;
      end
      scfla_pkg::DP_FAIL: begin
        pool_s_nxt = '0;
        pool_e_nxt = '0;
      end
      scfla_pkg::DP_CARVE_FIRST: begin
        ret_nxt    = pool_s_r;
        pool_s_nxt = pool_s_r + bsz;
        rem_nxt    = left - bsz;
        cnt_nxt    = NW'(1);
        prev_v_nxt = 1'b0;
      end
      scfla_pkg::DP_CARVE_STEP: begin
        if (sts.carve_more) begin
          // link previous carved block to this one
          if (prev_v_r) begin
            mem_we = 1'b1;
            mem_wa = prev_r[S +: LW];
            mem_wd = pool_s_r;
          end
          prev_nxt   = pool_s_r;
          prev_v_nxt = 1'b1;
          pool_s_nxt = pool_s_r + bsz;
          rem_nxt    = rem_r - bsz;
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          if (prev_v_r) begin
            mem_we = 1'b1;
            mem_wa = prev_r[S +: LW];
            mem_wd = NIL;
            heads_nxt[cls_r] = ret_r + bsz;
          end
          res_addr_nxt  = ret_r;
          res_grant_nxt = 1'b1;
        end
      end
      scfla_pkg::DP_EMIT: begin
        ov_nxt = 1'b1;
        oa_nxt = scfla_pkg::ADDR_W'(res_addr_r);
        og_nxt = res_grant_r;
        oo_nxt = res_over_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    rdata_r <= link_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CLASS_COUNT; i++) heads_r[i] <= NIL;
      pool_s_r <= '0;
      pool_e_r <= '0;
      top_r    <= '0;
      heap_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      heads_r  <= heads_nxt;
      pool_s_r <= pool_s_nxt;
      pool_e_r <= pool_e_nxt;
      top_r    <= top_nxt;
      heap_r   <= heap_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
    act_r <= act_nxt;  over_r <= over_nxt;  bad_r <= bad_nxt;
    cls_r <= cls_nxt;  k_r <= k_nxt;
    baddr_r <= baddr_nxt;  blk_r <= blk_nxt;
    ret_r <= ret_nxt;  prev_r <= prev_nxt;  prev_v_r <= prev_v_nxt;
    rem_r <= rem_nxt;  cnt_r <= cnt_nxt;
    res_addr_r <= res_addr_nxt;  res_grant_r <= res_grant_nxt;
    res_over_r <= res_over_nxt;
    oa_r <= oa_nxt;  og_r <= og_nxt;  oo_r <= oo_nxt;
  end

  assign out_valid    = ov_r;
  assign out_address  = oa_r;
  assign out_granted  = og_r;
  assign out_oversize = oo_r;

endmodule

### rtl/scfla_ctrl.sv
// ----------------------------------------------------------------------------
// scfla_ctrl - allocator sequencer
// Steps one request through the oversize or free path, or pop, refill, region take, scan and carve.
// ----------------------------------------------------------------------------
module scfla_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scfla_pkg::dp_sts_t sts,
  output scfla_pkg::dp_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECIDE = 11'b000_0000_0010,
    S_POP_RD = 11'b000_0000_0100,
    S_POP_WB = 11'b000_0000_1000,
    S_LEFT   = 11'b000_0001_0000,
    S_REGION = 11'b000_0010_0000,
    S_SCAN   = 11'b000_0100_0000,
    S_FB_WB  = 11'b000_1000_0000,
    S_CARVE0 = 11'b001_0000_0000,
    S_CARVE  = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = scfla_pkg::DP_NOP;
    cmd.sel_scan = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = scfla_pkg::DP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.oversize) begin
          cmd.op    = scfla_pkg::DP_SET_OVER;
          state_nxt = S_DONE;
        end else if (sts.act_free) begin
          cmd.op    = scfla_pkg::DP_FREE;
          state_nxt = S_DONE;
        end else if (!sts.head_nil) begin
          state_nxt = S_POP_RD;
        end else begin
          cmd.op = scfla_pkg::DP_CHK;
          if (!sts.left_lt)     state_nxt = S_CARVE0;
          else if (sts.left_nz) state_nxt = S_LEFT;
          else                  state_nxt = S_REGION;
        end
      end
      S_POP_RD: begin
        cmd.op    = scfla_pkg::DP_POP_RD;
        state_nxt = S_POP_WB;
      end
      S_POP_WB: begin
        cmd.op    = scfla_pkg::DP_POP_WB;
        state_nxt = S_DONE;
      end
      S_LEFT: begin
        cmd.op    = scfla_pkg::DP_PUSH_LEFT;
        state_nxt = S_REGION;
      end
      S_REGION: begin
        if (sts.region_fits) begin
          cmd.op    = scfla_pkg::DP_TAKE;
          state_nxt = S_CARVE0;
        end else begin
          cmd.op    = scfla_pkg::DP_SCAN_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_nil) begin
          cmd.op       = scfla_pkg::DP_POP_RD;
          cmd.sel_scan = 1'b1;
          state_nxt    = S_FB_WB;
        end else if (sts.scan_last) begin
          cmd.op    = scfla_pkg::DP_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.op = scfla_pkg::DP_SCAN_NEXT;
        end
      end
      S_FB_WB: begin
        cmd.op    = scfla_pkg::DP_FB_WB;
        state_nxt = S_CARVE0;
      end
      S_CARVE0: begin
        cmd.op    = scfla_pkg::DP_CARVE_FIRST;
        state_nxt = S_CARVE;
      end
      S_CARVE: begin
        cmd.op = scfla_pkg::DP_CARVE_STEP;
        if (!sts.carve_more) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = scfla_pkg::DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/size_class_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit - size-class pool allocator
// Serves alloc and free words against per-class free lists over a fixed arena.
// ----------------------------------------------------------------------------
// in_ch carries one request word: action (alloc/free), size_bytes and, for
// a free, block_address. out_ch returns one word per request: address,
// granted and oversize. Requests are handled one at a time.
// An oversize or free request goes straight to its result. An alloc pops
// the head of a non-empty class; else it carves from the current pool up
// to REFILL_OBJECTS blocks, of which the first is returned and the rest
// are linked onto the class list. A pool too short for one block has its
// leftover pushed onto a class list and a new region taken; when the arena
// is used up, a block is borrowed from the first non-empty class of equal
// or larger size, and the request is refused if there is none. The next
// request can be taken in the cycle after the result is loaded. One link
// is written per carved block and one class is looked at per scan cycle.
// in_ch.ready is high only while no request is in progress; a finished
// result sits in the output register, so the next request can be taken
// while out_ch is stalled, and its result waits until the slot frees.
// Reset empties all class lists, the pool and the arena; the link memory is
// not cleared, as every link is written before it is read.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_unit #(
  parameter int unsigned ALIGN_BYTES     = scfla_pkg::DEF_ALIGN_BYTES,
  parameter int unsigned MAX_CLASS_BYTES = scfla_pkg::DEF_MAX_CLASS_BYTES,
  parameter int unsigned CLASS_COUNT     = scfla_pkg::DEF_CLASS_COUNT,
  parameter int unsigned REFILL_OBJECTS  = scfla_pkg::DEF_REFILL_OBJECTS,
  parameter int unsigned ARENA_BYTES     = scfla_pkg::DEF_ARENA_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  scfla_in_if.sink    in_ch,
  scfla_out_if.source out_ch
);

  scfla_pkg::dp_cmd_t cmd;
  scfla_pkg::dp_sts_t sts;
  logic               rdy;

  assign in_ch.ready = rdy;

  scfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  scfla_dpath #(
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MAX_CLASS_BYTES (MAX_CLASS_BYTES),
    .CLASS_COUNT     (CLASS_COUNT),
    .REFILL_OBJECTS  (REFILL_OBJECTS),
    .ARENA_BYTES     (ARENA_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_action   (in_ch.action),
    .req_size     (in_ch.size_bytes),
    .req_baddr    (in_ch.block_address),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_address  (out_ch.address),
    .out_granted  (out_ch.granted),
    .out_oversize (out_ch.oversize)
  );

endmodule

### rtl/scfla_checker.sv
// ----------------------------------------------------------------------------
// scfla_checker - port-level checks for the allocator
// Result word consistency and request pacing, bound to the top level.
// ----------------------------------------------------------------------------
module scfla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_address,
  input logic        out_granted,
  input logic        out_oversize
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_no_grant_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && out_oversize))
    else $error("oversize request granted");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_address == 16'd0)
    else $error("address not zero on refused request");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind size_class_free_list_allocator_unit scfla_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_address  (out_ch.address),
  .out_granted  (out_ch.granted),
  .out_oversize (out_ch.oversize)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - size-class free-list allocator testbench
// A table of directed requests comes first, then random alloc/free traffic.
// The random traffic mixes allocs with frees of blocks it was granted earlier.
// Each result word is checked against the table's expected word or an allocator model kept here.
// The sender and receiver idle in several phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ALIGN    = scfla_pkg::DEF_ALIGN_BYTES;
  localparam int unsigned MAXB     = scfla_pkg::DEF_MAX_CLASS_BYTES;
  localparam int unsigned NCLASS   = scfla_pkg::DEF_CLASS_COUNT;
  localparam int unsigned REFILL   = scfla_pkg::DEF_REFILL_OBJECTS;
  localparam int unsigned ARENA    = scfla_pkg::DEF_ARENA_BYTES;
  localparam int unsigned NLINK    = ARENA / ALIGN;
  localparam int unsigned NIL      = 32'hFFFF_FFFF;
  localparam int unsigned WD_LIMIT = 4000;

  typedef struct packed {
    logic [scfla_pkg::ADDR_W-1:0] address;
    logic                         granted;
    logic                         oversize;
  } result_t;

  typedef struct packed {
    logic                         act;
    logic [scfla_pkg::SIZE_W-1:0] size;
    logic [15:0]                  baddr;
    logic                         typed;
    result_t                      res;
  } row_t;

  typedef struct {
    int unsigned addr;
    int unsigned size;
  } block_t;

  logic clk;
  logic rst_n;
  scfla_in_if  in_ch ();
  scfla_out_if out_ch ();

  size_class_free_list_allocator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // allocator model state
  int unsigned heads [NCLASS];
  int unsigned links [NLINK];
  int unsigned pool_lo, pool_hi, arena_top, heap_total;

  result_t results_due [$];
  block_t  live_blocks [$];
  int      errors = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct;
  int      stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned size_class(int unsigned sz);
    int unsigned g;
    int unsigned c;
    g = (sz + ALIGN - 1) / ALIGN;
    c = (g != 0) ? g - 1 : 0;
    if (c >= NCLASS) c = NCLASS - 1;
    return c;
  endfunction

  function automatic void set_link(int unsigned a, int unsigned nxt);
    if (a / ALIGN < NLINK) links[a / ALIGN] = nxt;
  endfunction

  function automatic void push_block(int unsigned c, int unsigned a);
    set_link(a, heads[c]);
    heads[c] = a;
  endfunction

  function automatic int unsigned pop_block(int unsigned c);
    int unsigned blk;
    blk = heads[c];
    heads[c] = (blk / ALIGN < NLINK) ? links[blk / ALIGN] : NIL;
    return blk;
  endfunction

  function automatic bit carve_blocks(int unsigned c, output int unsigned a);
    int unsigned bsz;
    int unsigned left;
    int unsigned region;
    int unsigned n;
    bit          found;
    bsz = (c + 1) * ALIGN;
    left = pool_hi - pool_lo;
    a = 0;
    if (left < bsz) begin
      region = 2 * bsz * REFILL + ((heap_total >> 4) + ALIGN - 1) / ALIGN * ALIGN;
      if (left > 0) push_block(size_class(left), pool_lo);
      if (region <= ARENA - arena_top) begin
        pool_lo = arena_top;
        pool_hi = arena_top + region;
        arena_top += region;
        heap_total += region;
      end else begin
        // arena used up: borrow the first block of an equal or larger class
        found = 0;
        for (int unsigned k = c; k < NCLASS && !found; k++) begin
          if (heads[k] != NIL) begin
            pool_lo = pop_block(k);
            pool_hi = pool_lo + (k + 1) * ALIGN;
            found = 1;
          end
        end
        if (!found) begin
          pool_lo = 0;
          pool_hi = 0;
          return 0;
        end
      end
      left = pool_hi - pool_lo;
      if (left < bsz) return 0;
    end
    n = left / bsz;
    if (n > REFILL) n = REFILL;
    a = pool_lo;
    pool_lo += n * bsz;
    if (n > 1) begin
      heads[c] = a + bsz;
      for (int unsigned i = 1; i < n; i++)
        set_link(a + i * bsz, (i == n - 1) ? NIL : a + (i + 1) * bsz);
    end
    return 1;
  endfunction

  function automatic result_t allocator_step(logic act, int unsigned sz, int unsigned ba);
    result_t     r;
    int unsigned c;
    int unsigned a;
    r = '0;
    if (sz > MAXB) begin
      r.oversize = 1'b1;
    end else if (act == scfla_pkg::ACT_ALLOC) begin
      c = size_class(sz);
      if (heads[c] != NIL) begin
        r.address = scfla_pkg::ADDR_W'(pop_block(c));
        r.granted = 1'b1;
      end else if (carve_blocks(c, a)) begin
        r.address = scfla_pkg::ADDR_W'(a);
        r.granted = 1'b1;
      end
    end else if (ba < ARENA && ba % ALIGN == 0) begin
      push_block(size_class(sz), ba);
      r.granted = 1'b1;
    end
    return r;
  endfunction

  // drive one request word; returns the model's result for it
  task automatic send_word(input logic act, input logic [scfla_pkg::SIZE_W-1:0] sz,
                           input logic [15:0] ba, input bit typed,
                           input result_t typed_res, output result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.size_bytes    <= sz;
    in_ch.block_address <= ba;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    res = allocator_step(act, 32'(sz), 32'(ba));
    results_due.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected: address %0h", out_ch.address);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.address !== want.address) begin
          $error("address: expected %0h, got %0h", want.address, out_ch.address);
          errors++;
        end
        if (out_ch.granted !== want.granted) begin
          $error("granted: expected %0b, got %0b", want.granted, out_ch.granted);
          errors++;
        end
        if (out_ch.oversize !== want.oversize) begin
          $error("oversize: expected %0b, got %0b", want.oversize, out_ch.oversize);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  row_t directed [20] = '{
    // first alloc after reset carves from a fresh region at address 0
    '{scfla_pkg::ACT_ALLOC, 12'd0,    16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{scfla_pkg::ACT_ALLOC, 12'd8,    16'h0000, 1'b1, '{16'h0008, 1'b1, 1'b0}},
    '{scfla_pkg::ACT_ALLOC, 12'd129,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{scfla_pkg::ACT_ALLOC, 12'd4095, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{scfla_pkg::ACT_FREE,  12'd4095, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{scfla_pkg::ACT_FREE,  12'd8,    16'h0003, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{scfla_pkg::ACT_FREE,  12'd8,    16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
    '{scfla_pkg::ACT_FREE,  12'd128,  16'hFFF8, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{scfla_pkg::ACT_ALLOC, 12'd128,  16'h0000, 1'b1, '{16'hFFF8, 1'b1, 1'b0}},
    '{scfla_pkg::ACT_ALLOC, 12'd1,    16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd9,    16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd128,  16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_FREE,  12'd0,    16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd0,    16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_FREE,  12'd16,   16'h0008, 1'b0, '0},
    '{scfla_pkg::ACT_FREE,  12'd16,   16'h0008, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd16,   16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd16,   16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd100,  16'h0000, 1'b0, '0},
    '{scfla_pkg::ACT_ALLOC, 12'd127,  16'h0000, 1'b0, '0}
  };

  initial begin
    result_t     res;
    block_t      blk;
    int unsigned pick;
    int          idle_plan [4][2];

    idle_plan = '{'{0, 0}, '{59, 0}, '{0, 59}, '{15, 15}};
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = scfla_pkg::ACT_ALLOC;
    in_ch.size_bytes = '0;
    in_ch.block_address = '0;
    foreach (heads[i]) heads[i] = NIL;
    foreach (links[i]) links[i] = 0;
    pool_lo = 0; pool_hi = 0; arena_top = 0; heap_total = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].act, directed[i].size, directed[i].baddr,
                directed[i].typed, directed[i].res, res);
    // sender holds off until the pipe is empty
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      stall_pct     = idle_plan[ph][1];
      for (int n = 0; n < 250; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // noise: any action, any size, any address
          send_word(1'($urandom_range(1)), 12'($urandom_range(4095)),
                    16'($urandom_range(65535)), 1'b0, '0, res);
        end else if (pick < 50 && live_blocks.size() != 0) begin
          pick = $urandom_range(live_blocks.size() - 1);
          blk = live_blocks[pick];
          live_blocks.delete(pick);
          send_word(scfla_pkg::ACT_FREE, 12'(blk.size), 16'(blk.addr), 1'b0, '0, res);
        end else begin
          blk.size = $urandom_range(MAXB);
          send_word(scfla_pkg::ACT_ALLOC, 12'(blk.size), 16'($urandom_range(65535)),
                    1'b0, '0, res);
          if (res.granted) begin
            blk.addr = res.address;
            live_blocks.push_back(blk);
          end
        end
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
